// ----- rtl/radar_tx_frequency_calibrator_unit_macros.svh -----
// assertion macros used by the calibrator checker
`ifndef RADAR_TX_FREQUENCY_CALIBRATOR_UNIT_MACROS_SVH
`define RADAR_TX_FREQUENCY_CALIBRATOR_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define RTFC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define RTFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/rtfc_pkg.sv -----
// types, constants and helper functions of the transmit frequency calibrator
package rtfc_pkg;

    localparam int unsigned FREQ_W   = 24;
    localparam int unsigned DIFF_W   = FREQ_W + 1;
    localparam int unsigned WORD_W   = 16;
    localparam int unsigned RAMP_W   = WORD_W + 1;
    localparam int unsigned TOL_W    = 16;
    localparam int unsigned STEP_W   = 10;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;
    localparam int unsigned IN_TDATA_W  = 24;
    localparam int unsigned OUT_TDATA_W = 72;
    localparam int unsigned RECIP_W     = WORD_W + 1;

    localparam int unsigned RAMP_POINTS_DEF = 256;

    localparam logic [WORD_W-1:0] RESET_START_WORD = 16'd25775;
    localparam logic [WORD_W-1:0] RESET_STOP_WORD  = 16'd30225;
    localparam logic signed [RAMP_W-1:0] RESET_BANDWIDTH =
        signed'({1'b0, RESET_STOP_WORD}) - signed'({1'b0, RESET_START_WORD});

    localparam logic [FREQ_W-1:0] RESET_TARGET_START = 24'd2929688;
    localparam logic [FREQ_W-1:0] RESET_TARGET_STOP  = 24'd2960205;
    localparam logic [TOL_W-1:0]  RESET_TOL_INITIAL  = 16'd120;
    localparam logic [TOL_W-1:0]  RESET_TOL_NORMAL   = 16'd365;
    localparam logic [STEP_W-1:0] RESET_DAC_STEP     = 10'd25;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FMCW_MODE    = 3'd0,
        REG_CALIB_ENABLE = 3'd1,
        REG_TARGET_START = 3'd2,
        REG_TARGET_STOP  = 3'd3,
        REG_TOL_INITIAL  = 3'd4,
        REG_TOL_NORMAL   = 3'd5,
        REG_DAC_STEP     = 3'd6
    } cfg_idx_t;

    // settings the step logic needs
    typedef struct packed {
        logic              fmcw_mode;
        logic              calib_enable;
        logic [TOL_W-1:0]  tol_initial;
        logic [TOL_W-1:0]  tol_normal;
        logic [STEP_W-1:0] dac_step;
    } cfg_t;

    // result of one calibration step, before the ramp increment
    typedef struct packed {
        logic [WORD_W-1:0]        start_dac;
        logic [WORD_W-1:0]        stop_dac;
        logic signed [RAMP_W-1:0] bandwidth_dac;
        logic                     initial_active;
        logic                     next_edge_stop;
        logic                     start_locked;
        logic                     stop_locked;
        logic                     dac_load;
    } step_res_t;

    // step a dac word by dac_step when the error is past the tolerance
    function automatic logic [WORD_W-1:0] trim_word(
        input logic [WORD_W-1:0]        word,
        input logic signed [DIFF_W-1:0] diff,
        input logic [TOL_W-1:0]         tol,
        input logic [STEP_W-1:0]        step
    );
        logic signed [DIFF_W-1:0] tol_s;
        logic [WORD_W:0]          sum;
        logic [WORD_W-1:0]        step_w;
        tol_s  = signed'({{(DIFF_W-TOL_W){1'b0}}, tol});
        step_w = {{(WORD_W-STEP_W){1'b0}}, step};
        sum    = {1'b0, word} + {1'b0, step_w};
        if (diff > tol_s)
            trim_word = (word > step_w) ? (word - step_w) : '0;
        else if (diff < -tol_s)
            trim_word = sum[WORD_W] ? '1 : sum[WORD_W-1:0];
        else
            trim_word = word;
    endfunction

    // strictly inside the tolerance band
    function automatic logic within_tol(
        input logic signed [DIFF_W-1:0] diff,
        input logic [TOL_W-1:0]         tol
    );
        logic signed [DIFF_W-1:0] tol_s;
        tol_s      = signed'({{(DIFF_W-TOL_W){1'b0}}, tol});
        within_tol = (diff < tol_s) && (diff > -tol_s);
    endfunction

endpackage

// ----- rtl/rtfc_state.sv -----
// calibration state: dac words, edge select, lock flags and ramp bandwidth
module rtfc_state
    import rtfc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step_en,
    input  logic signed [DIFF_W-1:0] d_start,
    input  logic signed [DIFF_W-1:0] d_stop,
    input  cfg_t                     cfg,
    output step_res_t                res
);

    logic [WORD_W-1:0]        start_word_reg, start_word_next;
    logic [WORD_W-1:0]        stop_word_reg, stop_word_next;
    logic signed [RAMP_W-1:0] bw_reg, bw_next;
    logic                     edge_reg, edge_next;
    logic                     start_done_reg, start_done_next;
    logic                     stop_done_reg, stop_done_next;
    logic                     lock_reg, lock_next;

    logic              in_lock;
    logic              edge_cur;
    logic              load;
    logic [TOL_W-1:0]  tol;
    logic signed [RAMP_W-1:0] bw_new;

    always_comb
    begin
        in_lock  = lock_reg & cfg.calib_enable;
        tol      = in_lock ? cfg.tol_initial : cfg.tol_normal;
        edge_cur = edge_reg & cfg.fmcw_mode;

        start_word_next = start_word_reg;
        stop_word_next  = stop_word_reg;
        if (!edge_cur)
            start_word_next = trim_word(start_word_reg, d_start, tol, cfg.dac_step);
        else
            stop_word_next = trim_word(stop_word_reg, d_stop, tol, cfg.dac_step);

        bw_new = signed'({1'b0, stop_word_next}) - signed'({1'b0, start_word_next});

        bw_next         = bw_reg;
        edge_next       = edge_reg;
        start_done_next = start_done_reg;
        stop_done_next  = stop_done_reg;
        lock_next       = lock_reg;
        load            = 1'b0;

        if (in_lock)
        begin
            if (within_tol(d_start, tol))
            begin
                start_done_next = 1'b1;
                edge_next       = ~edge_reg;
            end
            if (within_tol(d_stop, tol))
                stop_done_next = 1'b1;
            if (start_done_next && (stop_done_next || !cfg.fmcw_mode))
            begin
                lock_next = 1'b0;
                edge_next = 1'b0;
                if (cfg.fmcw_mode)
                    bw_next = bw_new;
            end
        end
        else
        begin
            if (cfg.fmcw_mode)
                edge_next = ~edge_cur;
            bw_next = bw_new;
            load    = 1'b1;
        end
        if (!cfg.fmcw_mode)
            edge_next = 1'b0;

        res.start_dac      = start_word_next;
        res.stop_dac       = stop_word_next;
        res.bandwidth_dac  = bw_next;
        res.initial_active = lock_next & cfg.calib_enable;
        res.next_edge_stop = edge_next;
        res.start_locked   = start_done_next;
        res.stop_locked    = stop_done_next | ~cfg.fmcw_mode;
        res.dac_load       = load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_word_reg <= RESET_START_WORD;
            stop_word_reg  <= RESET_STOP_WORD;
            bw_reg         <= RESET_BANDWIDTH;
            edge_reg       <= 1'b0;
            start_done_reg <= 1'b0;
            stop_done_reg  <= 1'b0;
            lock_reg       <= 1'b1;
        end
        else if (step_en)
        begin
            start_word_reg <= start_word_next;
            stop_word_reg  <= stop_word_next;
            bw_reg         <= bw_next;
            edge_reg       <= edge_next;
            start_done_reg <= start_done_next;
            stop_done_reg  <= stop_done_next;
            lock_reg       <= lock_next;
        end
    end

endmodule

// ----- rtl/radar_tx_frequency_calibrator_unit.sv -----
// top level of the radar transmit frequency calibrator
//
//  channel  | direction | payload
//  ---------+-----------+------------------------------------------------
//  s_t*     | in        | measured down-converted frequency, one per item
//  m_t*     | out       | dac words, ramp bandwidth and increment, flags
//  cfg_*    | in        | register writes, no read-back
//
//  one item per clock sustained, in and out, while m_tready is high
//  m_tvalid rises once an accepted item has passed the input, step
//  and divide registers, in that order
//  the step stage is the only place that touches calibration state, so the
//  next item sees the words and flags this one left
//  reset clears all state at once, no clearing pass
//  a stall on m_tready backs up through the three stages to s_tready
module radar_tx_frequency_calibrator_unit
    import rtfc_pkg::*;
#(
    parameter int unsigned RAMP_POINTS = RAMP_POINTS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [23:0] measured_freq
    // output stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [15:0] start_dac, [31:16] stop_dac, [48:32] bandwidth_dac,
    // [65:49] ramp_step_dac, [66] initial_active, [67] next_edge_stop,
    // [68] start_locked, [69] stop_locked, [70] dac_load, [71] zero
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // configuration writes
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // reciprocal for the divide by ramp length, exact for 16-bit magnitudes
    localparam int unsigned RampShift = WORD_W + $clog2(RAMP_POINTS);
    localparam logic [RECIP_W-1:0] RampRecip = RECIP_W'(
        ((64'd1 << RampShift) + 64'(RAMP_POINTS) - 64'd1) / 64'(RAMP_POINTS));
    localparam int unsigned ProdW = WORD_W + RECIP_W;

    // configuration registers
    logic              fmcw_mode_reg;
    logic              calib_enable_reg;
    logic [FREQ_W-1:0] target_start_reg;
    logic [FREQ_W-1:0] target_stop_reg;
    logic [TOL_W-1:0]  tol_initial_reg;
    logic [TOL_W-1:0]  tol_normal_reg;
    logic [STEP_W-1:0] dac_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmcw_mode_reg    <= 1'b1;
            calib_enable_reg <= 1'b1;
            target_start_reg <= RESET_TARGET_START;
            target_stop_reg  <= RESET_TARGET_STOP;
            tol_initial_reg  <= RESET_TOL_INITIAL;
            tol_normal_reg   <= RESET_TOL_NORMAL;
            dac_step_reg     <= RESET_DAC_STEP;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_FMCW_MODE:    fmcw_mode_reg    <= cfg_data[0];
                REG_CALIB_ENABLE: calib_enable_reg <= cfg_data[0];
                REG_TARGET_START: target_start_reg <= cfg_data[FREQ_W-1:0];
                REG_TARGET_STOP:  target_stop_reg  <= cfg_data[FREQ_W-1:0];
                REG_TOL_INITIAL:  tol_initial_reg  <= cfg_data[TOL_W-1:0];
                REG_TOL_NORMAL:   tol_normal_reg   <= cfg_data[TOL_W-1:0];
                REG_DAC_STEP:     dac_step_reg     <= cfg_data[STEP_W-1:0];
                default:          ;  // unused index, write dropped
            endcase
        end
    end

    // handshake chain: each stage loads when the one after it can take its item
    logic in_valid_reg, mid_valid_reg, out_valid_reg;
    logic out_ready, mid_ready, in_ready;
    logic s_accept, in_adv, mid_adv;

    assign out_ready = !out_valid_reg || m_tready;
    assign mid_ready = !mid_valid_reg || out_ready;
    assign in_ready  = !in_valid_reg  || mid_ready;
    assign s_tready  = in_ready;
    assign s_accept  = s_tvalid && in_ready;
    assign in_adv    = in_valid_reg && mid_ready;
    assign mid_adv   = mid_valid_reg && out_ready;
    assign m_tvalid  = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_accept)
                in_valid_reg <= 1'b1;
            else if (in_adv)
                in_valid_reg <= 1'b0;

            if (in_adv)
                mid_valid_reg <= 1'b1;
            else if (mid_adv)
                mid_valid_reg <= 1'b0;

            if (mid_adv)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // input stage: errors against both targets are taken at accept time;
    // the user must change targets only while the block is idle, the block does not enforce it
    logic signed [DIFF_W-1:0] d_start_reg, d_stop_reg;
    logic [FREQ_W-1:0]        meas;

    assign meas = s_tdata[FREQ_W-1:0];

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            d_start_reg <= signed'({1'b0, meas}) - signed'({1'b0, target_start_reg});
            d_stop_reg  <= signed'({1'b0, meas}) - signed'({1'b0, target_stop_reg});
        end
    end

    // step stage: trims one edge and updates the lock state
    cfg_t      cfg;
    step_res_t step_res;
    step_res_t mid_reg;

    assign cfg.fmcw_mode    = fmcw_mode_reg;
    assign cfg.calib_enable = calib_enable_reg;
    assign cfg.tol_initial  = tol_initial_reg;
    assign cfg.tol_normal   = tol_normal_reg;
    assign cfg.dac_step     = dac_step_reg;

    rtfc_state u_state (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (in_adv),
        .d_start (d_start_reg),
        .d_stop  (d_stop_reg),
        .cfg     (cfg),
        .res     (step_res)
    );

    always_ff @(posedge clk)
    begin
        if (in_adv)
            mid_reg <= step_res;
    end

    // divide stage: increment = bandwidth / ramp length, toward zero,
    // done on the magnitude by reciprocal multiply
    logic                     bw_neg;
    logic [RAMP_W-1:0]        bw_abs;
    logic [ProdW-1:0]         prod;
    logic [ProdW-1:0]         prod_sh;
    logic [WORD_W-1:0]        quot;
    logic signed [RAMP_W-1:0] incr_next;

    always_comb
    begin
        bw_neg    = mid_reg.bandwidth_dac[RAMP_W-1];
        bw_abs    = bw_neg ? RAMP_W'(-mid_reg.bandwidth_dac) : RAMP_W'(mid_reg.bandwidth_dac);
        prod      = {{RECIP_W{1'b0}}, bw_abs[WORD_W-1:0]} * {{WORD_W{1'b0}}, RampRecip};
        prod_sh   = prod >> RampShift;
        quot      = prod_sh[WORD_W-1:0];
        incr_next = bw_neg ? -signed'({1'b0, quot}) : signed'({1'b0, quot});
    end

    step_res_t                out_res_reg;
    logic signed [RAMP_W-1:0] out_incr_reg;

    always_ff @(posedge clk)
    begin
        if (mid_adv)
        begin
            out_res_reg  <= mid_reg;
            out_incr_reg <= incr_next;
        end
    end

    assign m_tdata = {
        1'b0,
        out_res_reg.dac_load,
        out_res_reg.stop_locked,
        out_res_reg.start_locked,
        out_res_reg.next_edge_stop,
        out_res_reg.initial_active,
        out_incr_reg,
        out_res_reg.bandwidth_dac,
        out_res_reg.stop_dac,
        out_res_reg.start_dac
    };

endmodule

// ----- rtl/rtfc_checker.sv -----
// port-level checks of the calibrator, bound to the top level
`include "radar_tx_frequency_calibrator_unit_macros.svh"

module rtfc_checker
    import rtfc_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    // a held result keeps its payload
    `RTFC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output changed while stalled")

    // a periodic step always leaves bandwidth equal to stop minus start
    `RTFC_ASSERT_NOW(a_bw_fresh, m_tvalid && m_tdata[70], $signed(m_tdata[48:32]) == ($signed({1'b0, m_tdata[31:16]}) - $signed({1'b0, m_tdata[15:0]})), "bandwidth not recomputed")

    // lock phase results never ask for a dac load
    `RTFC_ASSERT_NOW(a_lock_noload, m_tvalid && m_tdata[66], !m_tdata[70], "dac load during lock phase")

    // increment cannot be negative when bandwidth is not
    `RTFC_ASSERT_NOW(a_incr_sign, m_tvalid && !m_tdata[48], !m_tdata[65], "increment sign wrong")

endmodule

bind radar_tx_frequency_calibrator_unit rtfc_checker u_rtfc_checker (.*);
